@@ rtl/frp_pkg.sv @@
// shared types and constants of the framed relay pulse controller
// no dependencies; used by every rtl file of the block

package frp_pkg;

  // relay row
  localparam int RELAY_COUNT = 32;
  localparam int RELAY_W     = 32;
  localparam int RELAY_IDX_W = (RELAY_COUNT > 1) ? $clog2(RELAY_COUNT) : 1;

  // counters and bytes
  localparam int CNT_W    = 16;
  localparam int BYTE_W   = 8;
  localparam int ACTIVE_W = 6;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // framing
  localparam int WIN_LEN = 5;
  localparam logic [BYTE_W-1:0] FRAME_OUTER = 8'h15;
  localparam logic [BYTE_W-1:0] FRAME_INNER = 8'h05;
  localparam logic [1:0]        RELAY_TOP   = 2'b11;

  // configuration registers
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PULSE_LENGTH    = 2'd0,
    REG_BLINK_INTERVAL  = 2'd1,
    REG_CONNECT_CODE    = 2'd2,
    REG_DISCONNECT_CODE = 2'd3
  } cfg_reg_t;

  localparam logic [CNT_W-1:0]  PULSE_LENGTH_RST    = 16'd1500;
  localparam logic [CNT_W-1:0]  BLINK_INTERVAL_RST  = 16'd200;
  localparam logic [BYTE_W-1:0] CONNECT_CODE_RST    = 8'hA0;
  localparam logic [BYTE_W-1:0] DISCONNECT_CODE_RST = 8'hA1;

  // item kinds on in_tuser
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // output packing
  localparam int OUT_DATA_W = 56;

  // per-item control broadcast to the relay row
  typedef struct packed {
    logic                   tick;
    logic                   set;
    logic [RELAY_IDX_W-1:0] sel;
  } relay_ctl_t;

  // result fields travelling down the output pipeline
  typedef struct packed {
    logic [RELAY_W-1:0] relay_on;
    logic               link_up;
    logic               led_level;
    logic               frame_seen;
    logic [BYTE_W-1:0]  frame_command;
  } rslt_t;

endpackage

@@ rtl/frp_win_cell.sv @@
// one byte cell of the receive window shift chain
// depends on frp_pkg

module frp_win_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      shift_en,
  input  logic [frp_pkg::BYTE_W-1:0] d,
  output logic [frp_pkg::BYTE_W-1:0] q
);

  logic [frp_pkg::BYTE_W-1:0] byte_r;
  logic [frp_pkg::BYTE_W-1:0] byte_nxt;

  always_comb begin
    byte_nxt = shift_en ? d : byte_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign q = byte_r;

endmodule

@@ rtl/frp_relay_cell.sv @@
// one relay cell: on flag and saturating pulse counter
// depends on frp_pkg

module frp_relay_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [frp_pkg::RELAY_IDX_W-1:0] cell_idx,
  input  frp_pkg::relay_ctl_t             ctl,
  input  logic [frp_pkg::CNT_W-1:0]       pulse_length,
  output logic                            active
);

  logic                       active_r;
  logic                       active_nxt;
  logic [frp_pkg::CNT_W-1:0]  count_r;
  logic [frp_pkg::CNT_W-1:0]  count_nxt;
  logic [frp_pkg::CNT_W-1:0]  count_inc;

  always_comb begin
    active_nxt = active_r;
    count_nxt  = count_r;
    count_inc  = (count_r == frp_pkg::CNT_MAX) ? count_r : count_r + 1'b1;
    if (ctl.set && (ctl.sel == cell_idx)) begin
      active_nxt = 1'b1;
    end
    if (ctl.tick) begin
      if (active_r) begin
        if (count_inc > pulse_length) begin
          active_nxt = 1'b0;
          count_nxt  = '0;
        end else begin
          count_nxt = count_inc;
        end
      end else begin
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      count_r  <= '0;
    end else begin
      active_r <= active_nxt;
      count_r  <= count_nxt;
    end
  end

  assign active = active_r;

endmodule

@@ rtl/frp_popcount.sv @@
// two-stage registered population count of the relay mask
// depends on frp_pkg

module frp_popcount (
  input  logic                          clk,
  input  logic                          en,
  input  logic [frp_pkg::RELAY_W-1:0]   mask,
  output logic [frp_pkg::ACTIVE_W-1:0]  count
);

  localparam int GROUPS = frp_pkg::RELAY_W / 4;

  logic [GROUPS-1:0][2:0]          nib_r;
  logic [GROUPS-1:0][2:0]          nib_nxt;
  logic [frp_pkg::ACTIVE_W-1:0]    sum_r;
  logic [frp_pkg::ACTIVE_W-1:0]    sum_nxt;

  // first stage: ones per nibble
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      nib_nxt[g] = 3'(mask[4*g]) + 3'(mask[4*g+1]) + 3'(mask[4*g+2]) + 3'(mask[4*g+3]);
    end
  end

  // second stage: add the nibble counts
  always_comb begin
    sum_nxt = '0;
    for (int g = 0; g < GROUPS; g++) begin
      sum_nxt = sum_nxt + frp_pkg::ACTIVE_W'(nib_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nib_r <= nib_nxt;
      sum_r <= sum_nxt;
    end
  end

  assign count = sum_r;

endmodule

@@ rtl/framed_relay_pulse_controller_unit.sv @@
// top level of the framed relay pulse controller
// depends on frp_pkg, frp_win_cell, frp_relay_cell, frp_popcount

// Each request is a received link byte (in_tuser = 0) or a one millisecond
// tick (in_tuser = 1), and it yields exactly one result. Bytes shift through
// a chain of five byte cells; a frame 0x15,0x05,x,0x05,0x15 makes x the
// command. A command with top bits 11 and low bits n in 1..31 switches on
// relay n-1; a command equal to connect_code or disconnect_code (top bit set)
// raises or drops the link flag, connect winning when both match. Every relay
// is a cell of its own with a saturating counter, and on a tick all active
// cells count in parallel and switch off once past pulse_length. While the
// link is down the LED toggles once its count passes blink_interval. One
// request is taken every clock unless the pipeline stalls; the state updates
// in the accept cycle, and the result passes through stages 2 and 3 beside
// a two-stage registered population count of the relay mask. The pipeline
// stalls as a whole only while a result waits at the output. Configuration
// writes take effect on the next clock and are meant for idle periods.

module framed_relay_pulse_controller_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [frp_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [frp_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  // request channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // [7:0] rx_byte
  input  logic                                 in_tuser,   // [0] action
  // result channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [31:0] relay_on, [37:32] active_count, [38] link_up, [39] led_level,
  // [40] frame_seen, [48:41] frame_command, [55:49] zero
  output logic [frp_pkg::OUT_DATA_W-1:0]       out_tdata
);

  // configuration registers
  logic [frp_pkg::CNT_W-1:0]  pulse_length_r;
  logic [frp_pkg::CNT_W-1:0]  blink_interval_r;
  logic [frp_pkg::BYTE_W-1:0] connect_code_r;
  logic [frp_pkg::BYTE_W-1:0] disconnect_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_length_r    <= frp_pkg::PULSE_LENGTH_RST;
      blink_interval_r  <= frp_pkg::BLINK_INTERVAL_RST;
      connect_code_r    <= frp_pkg::CONNECT_CODE_RST;
      disconnect_code_r <= frp_pkg::DISCONNECT_CODE_RST;
    end else if (cfg_we) begin
      case (frp_pkg::cfg_reg_t'(cfg_addr))
        frp_pkg::REG_PULSE_LENGTH:    pulse_length_r    <= cfg_wdata;
        frp_pkg::REG_BLINK_INTERVAL:  blink_interval_r  <= cfg_wdata;
        frp_pkg::REG_CONNECT_CODE:    connect_code_r    <= cfg_wdata[frp_pkg::BYTE_W-1:0];
        frp_pkg::REG_DISCONNECT_CODE: disconnect_code_r <= cfg_wdata[frp_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: the whole pipe moves unless a result is stuck
  logic advance;
  logic accept;
  logic v1_r, v2_r, v3_r;

  assign advance   = !v3_r || out_tready;
  assign in_tready = advance;
  assign accept    = in_tvalid && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (advance) begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  logic is_tick;
  logic is_byte;
  assign is_tick = accept && (in_tuser == frp_pkg::ACT_TICK);
  assign is_byte = accept && (in_tuser == frp_pkg::ACT_BYTE);

  // receive window: cell 0 holds the oldest byte
  logic [frp_pkg::WIN_LEN-1:0][frp_pkg::BYTE_W-1:0] win_q;

  for (genvar k = 0; k < frp_pkg::WIN_LEN; k++) begin : g_win
    logic [frp_pkg::BYTE_W-1:0] cell_d;
    if (k == frp_pkg::WIN_LEN - 1) begin : g_head
      assign cell_d = in_tdata;
    end else begin : g_body
      assign cell_d = win_q[k+1];
    end
    frp_win_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (is_byte),
      .d        (cell_d),
      .q        (win_q[k])
    );
  end

  // frame check on the window as it stands after this byte shifts in
  logic                       frame_hit;
  logic [frp_pkg::BYTE_W-1:0] cmd;
  logic                       cmd_live;
  logic [4:0]                 relay_n;
  logic [4:0]                 relay_nm1;
  logic                       relay_hit;

  assign frame_hit = is_byte &&
                     (win_q[1] == frp_pkg::FRAME_OUTER) &&
                     (win_q[2] == frp_pkg::FRAME_INNER) &&
                     (win_q[4] == frp_pkg::FRAME_INNER) &&
                     (in_tdata == frp_pkg::FRAME_OUTER);
  assign cmd       = win_q[3];
  // commands with the top bit clear do nothing
  assign cmd_live  = frame_hit && cmd[7];
  assign relay_n   = cmd[4:0];
  assign relay_nm1 = relay_n - 5'd1;
  assign relay_hit = cmd_live && (cmd[7:6] == frp_pkg::RELAY_TOP) &&
                     (relay_n != 5'd0) &&
                     ({1'b0, relay_n} <= 6'(frp_pkg::RELAY_COUNT));

  // relay row
  frp_pkg::relay_ctl_t         relay_ctl;
  logic [frp_pkg::RELAY_W-1:0] relay_mask;

  assign relay_ctl.tick = is_tick;
  assign relay_ctl.set  = relay_hit;
  assign relay_ctl.sel  = relay_nm1[frp_pkg::RELAY_IDX_W-1:0];

  for (genvar i = 0; i < frp_pkg::RELAY_W; i++) begin : g_relay
    if (i < frp_pkg::RELAY_COUNT) begin : g_cell
      frp_relay_cell u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_idx     (frp_pkg::RELAY_IDX_W'(i)),
        .ctl          (relay_ctl),
        .pulse_length (pulse_length_r),
        .active       (relay_mask[i])
      );
    end else begin : g_none
      assign relay_mask[i] = 1'b0;
    end
  end

  // link flag and status led
  logic                       link_r, link_nxt;
  logic                       led_r, led_nxt;
  logic [frp_pkg::CNT_W-1:0]  blink_r, blink_nxt;
  logic [frp_pkg::CNT_W-1:0]  blink_inc;

  always_comb begin
    link_nxt  = link_r;
    led_nxt   = led_r;
    blink_nxt = blink_r;
    blink_inc = (blink_r == frp_pkg::CNT_MAX) ? blink_r : blink_r + 1'b1;
    if (cmd_live) begin
      if (cmd == connect_code_r) begin
        link_nxt = 1'b1;
      end else if (cmd == disconnect_code_r) begin
        link_nxt = 1'b0;
      end
    end
    if (accept) begin
      if (link_nxt) begin
        // link up holds the led dark
        led_nxt   = 1'b0;
        blink_nxt = '0;
      end else if (is_tick) begin
        if (blink_inc > blink_interval_r) begin
          led_nxt   = !led_r;
          blink_nxt = '0;
        end else begin
          blink_nxt = blink_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r  <= 1'b0;
      led_r   <= 1'b0;
      blink_r <= '0;
    end else begin
      link_r  <= link_nxt;
      led_r   <= led_nxt;
      blink_r <= blink_nxt;
    end
  end

  // per-request frame report, aligned with the updated state
  logic                       seen_r;
  logic [frp_pkg::BYTE_W-1:0] seen_cmd_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      seen_r     <= frame_hit;
      seen_cmd_r <= frame_hit ? cmd : '0;
    end
  end

  // result pipeline: stage 1 is the state itself, stages 2 and 3 carry it
  frp_pkg::rslt_t               s1_rslt;
  frp_pkg::rslt_t               s2_rslt_r;
  frp_pkg::rslt_t               s3_rslt_r;
  logic [frp_pkg::ACTIVE_W-1:0] active_cnt;

  assign s1_rslt.relay_on      = relay_mask;
  assign s1_rslt.link_up       = link_r;
  assign s1_rslt.led_level     = led_r;
  assign s1_rslt.frame_seen    = seen_r;
  assign s1_rslt.frame_command = seen_cmd_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_rslt_r <= s1_rslt;
      s3_rslt_r <= s2_rslt_r;
    end
  end

  frp_popcount u_popcount (
    .clk   (clk),
    .en    (advance),
    .mask  (relay_mask),
    .count (active_cnt)
  );

  assign out_tvalid = v3_r;
  assign out_tdata  = {7'd0,
                       s3_rslt_r.frame_command,
                       s3_rslt_r.frame_seen,
                       s3_rslt_r.led_level,
                       s3_rslt_r.link_up,
                       active_cnt,
                       s3_rslt_r.relay_on};

endmodule

@@ rtl/frp_checker.sv @@
// port-level checker for the framed relay pulse controller, with its bind
// depends on frp_pkg and framed_relay_pulse_controller_unit

module frp_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [frp_pkg::OUT_DATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // active count matches the relay mask
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($countones(out_tdata[31:0]) == 32'(out_tdata[37:32])))
    else $error("active count disagrees with relay mask");

  // led is dark while the link is up
  a_led_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[38] |-> !out_tdata[39])
    else $error("led lit with link up");

  // no frame, no command; relay 31 is out of reach of a frame
  a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[40] |-> (out_tdata[48:41] == 8'd0) && !out_tdata[31])
    else $error("command reported without frame");

  // padding stays clear
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[55:49] == 7'd0))
    else $error("padding bits set");

endmodule

bind framed_relay_pulse_controller_unit frp_checker u_frp_checker (.*);
